// ===== hdl/pvp_pkg.sv =====
// Shared types and constants of the perspective vertex projection unit.
// Item structs, configuration register indexes and internal word widths.
// Depends on nothing.
package pvp_pkg;

	localparam int COORD_W   = 24;
	localparam int TRIG_W    = 16;
	localparam int FOCAL_W   = 24;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_SH   = 14;

	localparam int DIFF_W  = COORD_W + 1;
	localparam int PROD1_W = DIFF_W + TRIG_W;
	localparam int SUM1_W  = PROD1_W + 1;
	localparam int ROT1_W  = 28;
	localparam int PROD2_W = ROT1_W + TRIG_W;
	localparam int SUM2_W  = PROD2_W + 1;
	localparam int ROT2_W  = 29;
	localparam int PRODX_W = ROT1_W + FOCAL_W + 1;
	localparam int PRODY_W = ROT2_W + FOCAL_W + 1;
	localparam int NUM_W   = 52;
	localparam int DEN_W   = ROT2_W - 1;
	localparam int QUO_W   = 24;
	localparam int SCR_W   = QUO_W + 2;

	localparam int DEF_SCREEN_WIDTH  = 1024;
	localparam int DEF_SCREEN_HEIGHT = 768;

	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAMERA_Z     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_COSINE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_YAW_SINE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_COSINE = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH_SINE   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL_LENGTH = 3'd7;

	typedef struct packed {
		logic signed [COORD_W-1:0] vertex_x;
		logic signed [COORD_W-1:0] vertex_y;
		logic signed [COORD_W-1:0] vertex_z;
	} vertex_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] screen_x;
		logic signed [COORD_W-1:0] screen_y;
		logic                      visible;
	} screen_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] camera_x;
		logic signed [COORD_W-1:0] camera_y;
		logic signed [COORD_W-1:0] camera_z;
		logic signed [TRIG_W-1:0]  yaw_cosine;
		logic signed [TRIG_W-1:0]  yaw_sine;
		logic signed [TRIG_W-1:0]  pitch_cosine;
		logic signed [TRIG_W-1:0]  pitch_sine;
		logic        [FOCAL_W-1:0] focal_length;
	} cfg_t;

	typedef struct packed {
		logic signed [ROT1_W-1:0] rx;
		logic signed [ROT2_W-1:0] ry;
		logic signed [ROT2_W-1:0] rz;
	} rot_t;

	typedef struct packed {
		logic              visible;
		logic              neg_x;
		logic              neg_y;
		logic              ovf_x;
		logic              ovf_y;
		logic [DEN_W-1:0]  den;
		logic [DEN_W-1:0]  rem_x;
		logic [DEN_W-1:0]  rem_y;
		logic [QUO_W-1:0]  nq_x;
		logic [QUO_W-1:0]  nq_y;
	} div_t;

endpackage

// ===== hdl/perspective_vertex_projection_unit.sv =====
// Top level of the perspective vertex projection unit: configuration
// registers, pipeline assembly and the saturating screen output stage.
// Depends on pvp_pkg, pvp_rotate, pvp_scale and pvp_divider.
//
// Usage:
//   vertex channel: one world-space vertex (Q15.8) per item, valid/ready.
//   screen channel: one projected item per vertex, valid/ready, same order.
//   cfg port: cfg_we writes cfg_data into the register at cfg_index at once;
//   write only while no vertex is in flight.
// From vertex accept to screen output the pipeline holds five stages of
// offset and rotation, two of focal scaling, 24 divider stages (one
// quotient bit each) and the output register.
// Throughput is one vertex per clock while the output is not stalled;
// every stage is a register with its own valid bit, so bubbles collapse.
// Reset empties the pipeline and loads the camera defaults: origin,
// zero yaw and pitch, focal length 512 pixels.
// When a valid output is not taken it holds; upstream stages keep filling
// empty slots and vertex_ready drops only once every stage is full.
module perspective_vertex_projection_unit
	import pvp_pkg::*;
#(
	parameter int SCREEN_WIDTH  = DEF_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = DEF_SCREEN_HEIGHT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	input  logic                 vertex_valid,
	output logic                 vertex_ready,
	input  vertex_t              vertex,
	output logic                 screen_valid,
	input  logic                 screen_ready,
	output screen_t              screen
);

	localparam logic signed [SCR_W-1:0] CENTER_X = SCR_W'((SCREEN_WIDTH / 2) * 256);
	localparam logic signed [SCR_W-1:0] CENTER_Y = SCR_W'((SCREEN_HEIGHT / 2) * 256);
	localparam logic signed [SCR_W-1:0] S24_MAX  = SCR_W'((1 << (COORD_W - 1)) - 1);
	localparam logic signed [SCR_W-1:0] S24_MIN  = -SCR_W'(1 << (COORD_W - 1));

	cfg_t    cfg_q;
	screen_t screen_q;
	logic    screen_valid_q;
	logic    out_adv;

	logic rot_valid, rot_ready, scl_valid, scl_ready, div_valid;
	rot_t rot_item;
	div_t scl_item, div_item;

	logic signed [SCR_W-1:0] px, py, sum_x, sum_y;
	screen_t                 screen_next;

	function automatic logic [COORD_W-1:0] sat24(input logic signed [SCR_W-1:0] v);
		if (v > S24_MAX) return S24_MAX[COORD_W-1:0];
		if (v < S24_MIN) return S24_MIN[COORD_W-1:0];
		return v[COORD_W-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_x     <= '0;
			cfg_q.camera_y     <= '0;
			cfg_q.camera_z     <= '0;
			cfg_q.yaw_cosine   <= TRIG_W'(16384);
			cfg_q.yaw_sine     <= '0;
			cfg_q.pitch_cosine <= TRIG_W'(16384);
			cfg_q.pitch_sine   <= '0;
			cfg_q.focal_length <= FOCAL_W'(131072);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CAMERA_X:     cfg_q.camera_x     <= cfg_data;
				REG_CAMERA_Y:     cfg_q.camera_y     <= cfg_data;
				REG_CAMERA_Z:     cfg_q.camera_z     <= cfg_data;
				REG_YAW_COSINE:   cfg_q.yaw_cosine   <= cfg_data[TRIG_W-1:0];
				REG_YAW_SINE:     cfg_q.yaw_sine     <= cfg_data[TRIG_W-1:0];
				REG_PITCH_COSINE: cfg_q.pitch_cosine <= cfg_data[TRIG_W-1:0];
				REG_PITCH_SINE:   cfg_q.pitch_sine   <= cfg_data[TRIG_W-1:0];
				REG_FOCAL_LENGTH: cfg_q.focal_length <= cfg_data[FOCAL_W-1:0];
				default: ;
			endcase
		end
	end

	pvp_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (vertex_valid),
		.in_ready  (vertex_ready),
		.in_item   (vertex),
		.out_valid (rot_valid),
		.out_ready (rot_ready),
		.out_item  (rot_item)
	);

	pvp_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (rot_valid),
		.in_ready  (rot_ready),
		.in_item   (rot_item),
		.out_valid (scl_valid),
		.out_ready (scl_ready),
		.out_item  (scl_item)
	);

	pvp_divider u_divider (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (scl_valid),
		.in_ready  (scl_ready),
		.in_item   (scl_item),
		.out_valid (div_valid),
		.out_ready (out_adv),
		.out_item  (div_item)
	);

	assign out_adv = !screen_valid_q || screen_ready;

	always_comb begin
		px    = div_item.neg_x ? -$signed({2'b00, div_item.nq_x}) : $signed({2'b00, div_item.nq_x});
		py    = div_item.neg_y ? -$signed({2'b00, div_item.nq_y}) : $signed({2'b00, div_item.nq_y});
		sum_x = CENTER_X + px;
		sum_y = CENTER_Y - py;
		screen_next.visible = div_item.visible;
		if (!div_item.visible) begin
			screen_next.screen_x = '0;
			screen_next.screen_y = '0;
		end else begin
			if (div_item.ovf_x) begin
				screen_next.screen_x = div_item.neg_x ? S24_MIN[COORD_W-1:0] : S24_MAX[COORD_W-1:0];
			end else begin
				screen_next.screen_x = sat24(sum_x);
			end
			if (div_item.ovf_y) begin
				screen_next.screen_y = div_item.neg_y ? S24_MAX[COORD_W-1:0] : S24_MIN[COORD_W-1:0];
			end else begin
				screen_next.screen_y = sat24(sum_y);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_valid_q <= 1'b0;
		end else if (out_adv) begin
			screen_valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv) begin
			screen_q <= screen_next;
		end
	end

	assign screen_valid = screen_valid_q;
	assign screen       = screen_q;

	a_culled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		screen_valid && !screen.visible |-> screen.screen_x == '0 && screen.screen_y == '0)
		else $error("culled item with nonzero coordinates");

	a_ready_flows: assert property (@(posedge clk) disable iff (!arst_n)
		screen_ready |-> vertex_ready)
		else $error("input stalled while output is taken");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!vertex_ready |-> screen_valid && !screen_ready)
		else $error("input stalled without a blocked output");

endmodule

// ===== hdl/pvp_rotate.sv =====
// Camera offset and yaw/pitch rotation, five pipeline stages.
// Uses pvp_pkg for the vertex, configuration and rotation structs.
module pvp_rotate
	import pvp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    in_valid,
	output logic    in_ready,
	input  vertex_t in_item,
	output logic    out_valid,
	input  logic    out_ready,
	output rot_t    out_item
);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;

	logic signed [DIFF_W-1:0]  dx_s1, dy_s1, dz_s1;
	logic signed [PROD1_W-1:0] p_xc_s2, p_zs_s2, p_xs_s2, p_zc_s2;
	logic signed [DIFF_W-1:0]  dy_s2, dy_s3;
	logic signed [ROT1_W-1:0]  rx_s3, t_s3, rx_s4, rx_s5;
	logic signed [PROD1_W-1:0] p_yc_s4, p_ys_s4;
	logic signed [PROD2_W-1:0] p_ts_s4, p_tc_s4;
	logic signed [ROT2_W-1:0]  ry_s5, rz_s5;

	logic signed [SUM1_W-1:0] sum_rx, sum_t;
	logic signed [SUM2_W-1:0] sum_ry, sum_rz;

	assign adv_s5   = !v_s5 || out_ready;
	assign adv_s4   = !v_s4 || adv_s5;
	assign adv_s3   = !v_s3 || adv_s4;
	assign adv_s2   = !v_s2 || adv_s3;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
			if (adv_s4) v_s4 <= v_s3;
			if (adv_s5) v_s5 <= v_s4;
		end
	end

	always_comb begin
		sum_rx = p_xc_s2 - p_zs_s2;
		sum_t  = p_xs_s2 + p_zc_s2;
		sum_ry = p_yc_s4 - p_ts_s4;
		sum_rz = p_ys_s4 + p_tc_s4;
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			dx_s1 <= $signed({in_item.vertex_x[COORD_W-1], in_item.vertex_x})
				- $signed({cfg.camera_x[COORD_W-1], cfg.camera_x});
			dy_s1 <= $signed({in_item.vertex_y[COORD_W-1], in_item.vertex_y})
				- $signed({cfg.camera_y[COORD_W-1], cfg.camera_y});
			dz_s1 <= $signed({in_item.vertex_z[COORD_W-1], in_item.vertex_z})
				- $signed({cfg.camera_z[COORD_W-1], cfg.camera_z});
		end
		if (adv_s2) begin
			p_xc_s2 <= dx_s1 * $signed(cfg.yaw_cosine);
			p_zs_s2 <= dz_s1 * $signed(cfg.yaw_sine);
			p_xs_s2 <= dx_s1 * $signed(cfg.yaw_sine);
			p_zc_s2 <= dz_s1 * $signed(cfg.yaw_cosine);
			dy_s2   <= dy_s1;
		end
		if (adv_s3) begin
			rx_s3 <= sum_rx[FRAC_SH+ROT1_W-1:FRAC_SH];
			t_s3  <= sum_t[FRAC_SH+ROT1_W-1:FRAC_SH];
			dy_s3 <= dy_s2;
		end
		if (adv_s4) begin
			p_yc_s4 <= dy_s3 * $signed(cfg.pitch_cosine);
			p_ts_s4 <= t_s3 * $signed(cfg.pitch_sine);
			p_ys_s4 <= dy_s3 * $signed(cfg.pitch_sine);
			p_tc_s4 <= t_s3 * $signed(cfg.pitch_cosine);
			rx_s4   <= rx_s3;
		end
		if (adv_s5) begin
			ry_s5 <= sum_ry[FRAC_SH+ROT2_W-1:FRAC_SH];
			rz_s5 <= sum_rz[FRAC_SH+ROT2_W-1:FRAC_SH];
			rx_s5 <= rx_s4;
		end
	end

	assign out_valid   = v_s5;
	assign out_item.rx = rx_s5;
	assign out_item.ry = ry_s5;
	assign out_item.rz = rz_s5;

endmodule

// ===== hdl/pvp_scale.sv =====
// Focal length scaling and divider setup, two pipeline stages.
// Uses pvp_pkg for the configuration, rotation and divider structs.
module pvp_scale
	import pvp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  cfg_t cfg,
	input  logic in_valid,
	output logic in_ready,
	input  rot_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_item
);

	logic v_s1, v_s2;
	logic adv_s1, adv_s2;

	logic signed [PRODX_W-1:0] px_s1;
	logic signed [PRODY_W-1:0] py_s1;
	logic signed [ROT2_W-1:0]  rz_s1;
	div_t                      div_s2;

	logic [NUM_W-1:0] mag_x, mag_y;
	logic [DEN_W-1:0] den;
	div_t             div_next;

	assign adv_s2   = !v_s2 || out_ready;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
		end
	end

	always_comb begin
		mag_x = px_s1[PRODX_W-1] ? NUM_W'(-px_s1) : NUM_W'(px_s1);
		mag_y = py_s1[PRODY_W-1] ? NUM_W'(-py_s1) : NUM_W'(py_s1);
		den   = rz_s1[DEN_W-1:0];
		div_next.visible = !rz_s1[ROT2_W-1] && (rz_s1 != '0);
		div_next.neg_x   = px_s1[PRODX_W-1];
		div_next.neg_y   = py_s1[PRODY_W-1];
		div_next.ovf_x   = mag_x[NUM_W-1:QUO_W] >= den;
		div_next.ovf_y   = mag_y[NUM_W-1:QUO_W] >= den;
		div_next.den     = den;
		div_next.rem_x   = mag_x[NUM_W-1:QUO_W];
		div_next.rem_y   = mag_y[NUM_W-1:QUO_W];
		div_next.nq_x    = mag_x[QUO_W-1:0];
		div_next.nq_y    = mag_y[QUO_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			px_s1 <= $signed(in_item.rx) * $signed({1'b0, cfg.focal_length});
			py_s1 <= $signed(in_item.ry) * $signed({1'b0, cfg.focal_length});
			rz_s1 <= in_item.rz;
		end
		if (adv_s2) begin
			div_s2 <= div_next;
		end
	end

	assign out_valid = v_s2;
	assign out_item  = div_s2;

endmodule

// ===== hdl/pvp_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage for both lanes.
// Uses pvp_pkg for the divider struct and the quotient width.
module pvp_divider
	import pvp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  div_t in_item,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_item
);

	localparam int STAGES = QUO_W;

	logic [STAGES-1:0] valid_sn;
	logic [STAGES-1:0] adv_sn;
	div_t              stage_sn [STAGES];
	div_t              step_sn  [STAGES];

	function automatic logic [DEN_W+QUO_W-1:0] lane_step(
		input logic [DEN_W-1:0] rem,
		input logic [QUO_W-1:0] nq,
		input logic [DEN_W-1:0] den
	);
		logic [DEN_W:0]   cand;
		logic [DEN_W:0]   diff;
		logic             ge;
		logic [DEN_W-1:0] rem_n;
		cand  = {rem, nq[QUO_W-1]};
		diff  = cand - {1'b0, den};
		ge    = cand >= {1'b0, den};
		rem_n = ge ? diff[DEN_W-1:0] : cand[DEN_W-1:0];
		return {rem_n, nq[QUO_W-2:0], ge};
	endfunction

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		div_t src;
		logic src_valid;

		if (k == 0) begin : g_first
			assign src       = in_item;
			assign src_valid = in_valid;
		end else begin : g_next
			assign src       = stage_sn[k-1];
			assign src_valid = valid_sn[k-1];
		end

		assign adv_sn[k] = out_ready || !(&valid_sn[STAGES-1:k]);

		always_comb begin
			step_sn[k] = src;
			{step_sn[k].rem_x, step_sn[k].nq_x} = lane_step(src.rem_x, src.nq_x, src.den);
			{step_sn[k].rem_y, step_sn[k].nq_y} = lane_step(src.rem_y, src.nq_y, src.den);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_sn[k] <= 1'b0;
			end else if (adv_sn[k]) begin
				valid_sn[k] <= src_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (adv_sn[k]) begin
				stage_sn[k] <= step_sn[k];
			end
		end
	end

	assign in_ready  = adv_sn[0];
	assign out_valid = valid_sn[STAGES-1];
	assign out_item  = stage_sn[STAGES-1];

endmodule
